/* rtl/csm_pkg.sv */
// Package with the beat types, byte codes, mode encoding and mode step function of the minifier.
package csm_pkg;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [14:0] {
    M_NORMAL   = 15'b000000000000001,
    M_SLASH    = 15'b000000000000010,
    M_CSTART   = 15'b000000000000100,
    M_CKEEP    = 15'b000000000001000,
    M_CKEEP_ST = 15'b000000000010000,
    M_CDROP    = 15'b000000000100000,
    M_CDROP_ST = 15'b000000001000000,
    M_SPACES   = 15'b000000010000000,
    M_SEMI     = 15'b000000100000000,
    M_NOWS     = 15'b000001000000000,
    M_COLON    = 15'b000010000000000,
    M_DQ       = 15'b000100000000000,
    M_DQ_BS    = 15'b001000000000000,
    M_SQ       = 15'b010000000000000,
    M_SQ_BS    = 15'b100000000000000
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } text_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_end;
    logic       stream_done;
  } mini_beat_t;

  typedef struct packed {
    mode_t      mode;
    logic       again;
    logic [1:0] n;
    logic [7:0] e1;
    logic [7:0] e0;
  } step_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      nm1;
    logic            bare;
    logic            done;
  } grp_t;

  function automatic logic is_ws(logic [7:0] b);
    return (b == CH_SPACE) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_ctl(logic [7:0] b);
    return (b < 8'h20) || (b == 8'h7F);
  endfunction

  // One pass of the mode machine; again asks for the same byte to be fed once more.
  function automatic step_t csm_step(mode_t m, logic [7:0] b);
    step_t      s;
    logic [7:0] q;
    mode_t      ret;
    s.mode  = m;
    s.again = 1'b0;
    s.n     = 2'd0;
    s.e0    = 8'h00;
    s.e1    = 8'h00;
    q       = (m == M_DQ_BS) ? CH_DQUOTE : CH_SQUOTE;
    ret     = (m == M_DQ_BS) ? M_DQ : M_SQ;
    case (m)
      M_SLASH: begin
        if (b == CH_STAR) begin
          s.mode = M_CSTART;
        end else begin
          s.n = 2'd1; s.e0 = CH_SLASH; s.mode = M_NORMAL; s.again = 1'b1;
        end
      end
      M_CSTART: begin
        if (b == CH_DASH) begin
          s.mode = M_CDROP;
        end else begin
          s.n = 2'd2; s.e0 = CH_SLASH; s.e1 = CH_STAR;
          s.mode = M_CKEEP; s.again = 1'b1;
        end
      end
      M_CKEEP: begin
        if (b == CH_STAR) begin
          s.mode = M_CKEEP_ST;
        end else if (!is_ctl(b)) begin
          s.n = 2'd1; s.e0 = b;
        end
      end
      M_CKEEP_ST: begin
        s.n = 2'd1; s.e0 = CH_STAR;
        if (b == CH_SLASH) begin
          s.n = 2'd2; s.e1 = CH_SLASH; s.mode = M_NORMAL;
        end else begin
          s.mode = M_CKEEP; s.again = 1'b1;
        end
      end
      M_CDROP: begin
        if (b == CH_STAR) begin
          s.mode = M_CDROP_ST;
        end
      end
      M_CDROP_ST: begin
        if (b == CH_SLASH) begin
          s.mode = M_NORMAL;
        end else begin
          s.mode = M_CDROP; s.again = 1'b1;
        end
      end
      M_SPACES: begin
        s.mode = M_NORMAL;
        if (b == CH_LBRACE || b == CH_RBRACE) begin
          s.again = 1'b1;
        end else if (!is_ws(b)) begin
          s.n = 2'd1; s.e0 = CH_SPACE; s.again = 1'b1;
        end
      end
      M_SEMI: begin
        if (!is_ws(b)) begin
          if (b != CH_RBRACE) begin
            s.n = 2'd1; s.e0 = CH_SEMI;
          end
          s.mode = M_NORMAL; s.again = 1'b1;
        end
      end
      M_NOWS: begin
        if (!is_ws(b)) begin
          s.mode = M_NORMAL; s.again = 1'b1;
        end
      end
      M_COLON: begin
        if (is_ws(b)) begin
          s.n = 2'd1; s.e0 = CH_SPACE; s.mode = M_NOWS;
        end else begin
          s.mode = M_NORMAL; s.again = 1'b1;
        end
      end
      M_DQ: begin
        if (b == CH_BSLASH) begin
          s.mode = M_DQ_BS;
        end else if (b == CH_DQUOTE) begin
          s.n = 2'd1; s.e0 = b; s.mode = M_NORMAL;
        end else if (!is_ctl(b)) begin
          s.n = 2'd1; s.e0 = b;
        end
      end
      M_SQ: begin
        if (b == CH_BSLASH) begin
          s.mode = M_SQ_BS;
        end else if (b == CH_SQUOTE) begin
          s.n = 2'd1; s.e0 = b; s.mode = M_NORMAL;
        end else if (!is_ctl(b)) begin
          s.n = 2'd1; s.e0 = b;
        end
      end
      M_DQ_BS, M_SQ_BS: begin
        s.n = 2'd1; s.e0 = CH_BSLASH; s.mode = ret;
        if (b == q || b == CH_BSLASH) begin
          s.n = 2'd2; s.e1 = b;
        end else begin
          s.again = 1'b1;
        end
      end
      default: begin
        s.mode = M_NORMAL;
        if (b == CH_SLASH) begin
          s.mode = M_SLASH;
        end else if (b == CH_DQUOTE) begin
          s.n = 2'd1; s.e0 = b; s.mode = M_DQ;
        end else if (b == CH_SQUOTE) begin
          s.n = 2'd1; s.e0 = b; s.mode = M_SQ;
        end else if (b == CH_SEMI) begin
          s.mode = M_SEMI;
        end else if (b == CH_COLON) begin
          s.n = 2'd1; s.e0 = b; s.mode = M_COLON;
        end else if (b == CH_COMMA || b == CH_LBRACE || b == CH_RBRACE) begin
          s.n = 2'd1; s.e0 = b; s.mode = M_NOWS;
        end else if (is_ws(b)) begin
          s.mode = M_SPACES;
        end else begin
          s.n = 2'd1; s.e0 = b;
        end
      end
    endcase
    return s;
  endfunction

endpackage

/* rtl/css_stream_minifier_core.sv */
// Top level of the streaming CSS minifier: mode machine, result queue and output sequencing.
// The block takes one CSS byte per cycle on the text channel and returns the minified
// bytes on the mini channel, one result per beat. A byte is decoded in the cycle it is
// accepted: the mode register and the byte feed two chained passes of the mode machine,
// and the up to four results it causes are written as one group into a two-group queue.
// The output side then sends the head group one result per unstalled cycle, so the input
// runs at one byte per cycle while the output is not stalled and no byte causes more than
// one result; a byte with more results keeps the output busy with one beat per result, and
// the input stalls once two groups wait. The queue depth of two groups sets how far the
// input may run ahead of a stalled output. A byte that causes no result leaves nothing in
// the queue. The final byte of a stream always yields at least one beat, a bare end marker
// if nothing else, and leaves the block ready for a new stream.
module css_stream_minifier_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                text_valid,
  output logic                text_stall,
  input  csm_pkg::text_beat_t text_data,
  output logic                mini_valid,
  input  logic                mini_stall,
  output csm_pkg::mini_beat_t mini_data
);
  import csm_pkg::*;

  mode_t      mode;
  mode_t      mode_next;
  mode_t      mode_after;
  logic       prev_space;
  logic       prev_space_next;
  step_t      s1;
  step_t      s2;
  logic       drop;
  logic       flush;
  logic [7:0] flush_byte;
  logic [31:0] res_bytes;
  logic [2:0] cnt;
  logic [2:0] cnt_m1;
  grp_t       grp_new;
  grp_t       q_mem [2];
  grp_t       head;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] q_count;
  logic [1:0] rd_idx;
  logic       in_acc;
  logic       out_acc;
  logic       enq;
  logic       pop;

  assign in_acc     = text_valid && !text_stall;
  assign out_acc    = mini_valid && !mini_stall;
  assign text_stall = (q_count == 2'd2);
  assign mini_valid = (q_count != 2'd0);
  assign head       = q_mem[rd_ptr];
  assign pop        = out_acc && (rd_idx == head.nm1);
  assign enq        = in_acc && ((cnt != 3'd0) || text_data.is_last);

  always_comb begin
    s1   = csm_step(mode, text_data.in_byte);
    s2   = csm_step(s1.mode, text_data.in_byte);
    drop = (text_data.in_byte == CH_SPACE) && prev_space;
    res_bytes = {16'h0000, s1.e1, s1.e0}
              | (s1.again ? ({16'h0000, s2.e1, s2.e0} << {s1.n, 3'b000}) : 32'h0000_0000);
    cnt        = {1'b0, s1.n} + (s1.again ? {1'b0, s2.n} : 3'd0);
    mode_after = s1.again ? s2.mode : s1.mode;
    if (drop) begin
      res_bytes  = 32'h0000_0000;
      cnt        = 3'd0;
      mode_after = mode;
    end
    flush      = 1'b0;
    flush_byte = 8'h00;
    case (mode_after)
      M_SLASH: begin
        flush = 1'b1; flush_byte = CH_SLASH;
      end
      M_CKEEP_ST: begin
        flush = 1'b1; flush_byte = CH_STAR;
      end
      M_DQ_BS, M_SQ_BS: begin
        flush = 1'b1; flush_byte = CH_BSLASH;
      end
      default: begin
        flush = 1'b0;
      end
    endcase
    if (text_data.is_last && flush && cnt != 3'd4) begin
      res_bytes = res_bytes | ({24'h000000, flush_byte} << {cnt[1:0], 3'b000});
      cnt       = cnt + 3'd1;
    end
    cnt_m1        = cnt - 3'd1;
    grp_new.bytes = res_bytes;
    grp_new.bare  = (cnt == 3'd0);
    grp_new.nm1   = (cnt == 3'd0) ? 2'd0 : cnt_m1[1:0];
    grp_new.done  = text_data.is_last;
    if (text_data.is_last) begin
      mode_next       = M_NORMAL;
      prev_space_next = 1'b0;
    end else begin
      mode_next       = mode_after;
      prev_space_next = (text_data.in_byte == CH_SPACE);
    end
  end

  always_comb begin
    mini_data.out_byte    = head.bare ? 8'h00 : head.bytes[rd_idx];
    mini_data.byte_valid  = !head.bare;
    mini_data.run_end     = (rd_idx == head.nm1);
    mini_data.stream_done = head.done && (rd_idx == head.nm1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_NORMAL;
      prev_space <= 1'b0;
      wr_ptr     <= 1'b0;
      rd_ptr     <= 1'b0;
      q_count    <= 2'd0;
      rd_idx     <= 2'd0;
    end else begin
      if (in_acc) begin
        mode       <= mode_next;
        prev_space <= prev_space_next;
      end
      if (enq) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
        rd_idx <= 2'd0;
      end else if (out_acc) begin
        rd_idx <= rd_idx + 2'd1;
      end
      q_count <= q_count + {1'b0, enq} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_mem[wr_ptr] <= grp_new;
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count != 2'd3)
    else $error("Result queue count out of range.");

  a_idx_in_group: assert property (@(posedge clk) disable iff (rst)
    mini_valid |-> rd_idx <= head.nm1)
    else $error("Result index ran past the end of its group.");

  a_bare_ends_run: assert property (@(posedge clk) disable iff (rst)
    (mini_valid && !mini_data.byte_valid) |-> (mini_data.run_end && mini_data.stream_done))
    else $error("Bare end marker is not the final beat of the stream.");

  a_last_resets_mode: assert property (@(posedge clk) disable iff (rst)
    (in_acc && text_data.is_last) |=> (mode == M_NORMAL && !prev_space))
    else $error("Mode not restored after the final byte of a stream.");

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the CSS stream minifier core: directed and random byte streams.
module testbench;
  import csm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BEATS   = 360;
  localparam int HOLD_START     = 120;
  localparam int HOLD_CYCLES    = 80;
  localparam int QUIET_FIRST    = 200;
  localparam int QUIET_LAST     = 280;
  localparam int POST_CYCLES    = 20;

  typedef struct {
    text_beat_t beat;
    bit         hold;
  } text_job_t;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       text_valid = 1'b0;
  logic       text_stall;
  text_beat_t text_data  = '0;
  logic       mini_valid;
  logic       mini_stall = 1'b0;
  mini_beat_t mini_data;

  text_job_t  text_jobs[$];
  text_job_t  next_job;
  logic [7:0] stream_bytes[$];
  mini_beat_t byte_group[$];
  mini_beat_t due_beats[$];
  mini_beat_t want;

  mode_t      text_mode      = M_NORMAL;
  logic       last_raw_space = 1'b0;
  logic       text_took      = 1'b0;
  int         text_count     = 0;
  int         fail_count     = 0;
  int         idle_streak    = 0;
  int         hold_left      = 0;
  bit         held_once      = 1'b0;
  logic       quiet_phase;

  assign quiet_phase = (text_count >= QUIET_FIRST) && (text_count < QUIET_LAST);

  css_stream_minifier_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_data  (text_data),
    .mini_valid (mini_valid),
    .mini_stall (mini_stall),
    .mini_data  (mini_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic blank_byte(logic [7:0] b);
    return b inside {CH_SPACE, [8'h09:8'h0D]};
  endfunction

  function automatic logic control_byte(logic [7:0] b);
    return b inside {[8'h00:8'h1F], 8'h7F};
  endfunction

  task automatic put_byte(input logic [7:0] c);
    mini_beat_t r;
    if (byte_group.size() < 4) begin
      r = '0;
      r.out_byte = c;
      r.byte_valid = 1'b1;
      byte_group.push_back(r);
    end
  endtask

  task automatic quoted_byte(input logic [7:0] b, input logic [7:0] q, input mode_t esc);
    if (b == CH_BSLASH) begin
      text_mode = esc;
    end else if (b == q) begin
      put_byte(b);
      text_mode = M_NORMAL;
    end else if (!control_byte(b)) begin
      put_byte(b);
    end
  endtask

  task automatic run_modes(input logic [7:0] b);
    logic       again;
    logic [7:0] q;
    do begin
      again = 1'b0;
      case (text_mode)
        M_SLASH: begin
          if (b == CH_STAR) begin
            text_mode = M_CSTART;
          end else begin
            put_byte(CH_SLASH);
            text_mode = M_NORMAL;
            again = 1'b1;
          end
        end
        M_CSTART: begin
          if (b == CH_DASH) begin
            text_mode = M_CDROP;
          end else begin
            put_byte(CH_SLASH);
            put_byte(CH_STAR);
            text_mode = M_CKEEP;
            again = 1'b1;
          end
        end
        M_CKEEP: begin
          if (b == CH_STAR) begin
            text_mode = M_CKEEP_ST;
          end else if (!control_byte(b)) begin
            put_byte(b);
          end
        end
        M_CKEEP_ST: begin
          put_byte(CH_STAR);
          if (b == CH_SLASH) begin
            put_byte(CH_SLASH);
            text_mode = M_NORMAL;
          end else begin
            text_mode = M_CKEEP;
            again = 1'b1;
          end
        end
        M_CDROP: begin
          if (b == CH_STAR) begin
            text_mode = M_CDROP_ST;
          end
        end
        M_CDROP_ST: begin
          if (b == CH_SLASH) begin
            text_mode = M_NORMAL;
          end else begin
            text_mode = M_CDROP;
            again = 1'b1;
          end
        end
        M_SPACES: begin
          text_mode = M_NORMAL;
          if (b == CH_LBRACE || b == CH_RBRACE) begin
            again = 1'b1;
          end else if (!blank_byte(b)) begin
            put_byte(CH_SPACE);
            again = 1'b1;
          end
        end
        M_SEMI: begin
          if (!blank_byte(b)) begin
            if (b != CH_RBRACE) begin
              put_byte(CH_SEMI);
            end
            text_mode = M_NORMAL;
            again = 1'b1;
          end
        end
        M_NOWS: begin
          if (!blank_byte(b)) begin
            text_mode = M_NORMAL;
            again = 1'b1;
          end
        end
        M_COLON: begin
          if (blank_byte(b)) begin
            put_byte(CH_SPACE);
            text_mode = M_NOWS;
          end else begin
            text_mode = M_NORMAL;
            again = 1'b1;
          end
        end
        M_DQ: begin
          quoted_byte(b, CH_DQUOTE, M_DQ_BS);
        end
        M_SQ: begin
          quoted_byte(b, CH_SQUOTE, M_SQ_BS);
        end
        M_DQ_BS, M_SQ_BS: begin
          q = (text_mode == M_DQ_BS) ? CH_DQUOTE : CH_SQUOTE;
          put_byte(CH_BSLASH);
          text_mode = (text_mode == M_DQ_BS) ? M_DQ : M_SQ;
          if (b == q || b == CH_BSLASH) begin
            put_byte(b);
          end else begin
            again = 1'b1;
          end
        end
        default: begin
          text_mode = M_NORMAL;
          if (b == CH_SLASH) begin
            text_mode = M_SLASH;
          end else if (b == CH_DQUOTE) begin
            put_byte(b);
            text_mode = M_DQ;
          end else if (b == CH_SQUOTE) begin
            put_byte(b);
            text_mode = M_SQ;
          end else if (b == CH_SEMI) begin
            text_mode = M_SEMI;
          end else if (b == CH_COLON) begin
            put_byte(b);
            text_mode = M_COLON;
          end else if (b == CH_COMMA || b == CH_LBRACE || b == CH_RBRACE) begin
            put_byte(b);
            text_mode = M_NOWS;
          end else if (blank_byte(b)) begin
            text_mode = M_SPACES;
          end else begin
            put_byte(b);
          end
        end
      endcase
    end while (again);
  endtask

  task automatic minify_byte(input text_beat_t t);
    byte_group.delete();
    if (!(t.in_byte == CH_SPACE && last_raw_space)) begin
      run_modes(t.in_byte);
    end
    last_raw_space = (t.in_byte == CH_SPACE);
    if (t.is_last) begin
      case (text_mode)
        M_SLASH: begin
          put_byte(CH_SLASH);
        end
        M_CKEEP_ST: begin
          put_byte(CH_STAR);
        end
        M_DQ_BS, M_SQ_BS: begin
          put_byte(CH_BSLASH);
        end
        default: begin
        end
      endcase
      if (byte_group.size() == 0) begin
        byte_group.push_back('0);
      end
      byte_group[byte_group.size() - 1].stream_done = 1'b1;
      text_mode = M_NORMAL;
      last_raw_space = 1'b0;
    end
    if (byte_group.size() > 0) begin
      byte_group[byte_group.size() - 1].run_end = 1'b1;
    end
    foreach (byte_group[i]) begin
      due_beats.push_back(byte_group[i]);
    end
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      stream_bytes.push_back(s[i]);
    end
  endtask

  task automatic close_stream(input bit hold);
    text_job_t j;
    foreach (stream_bytes[i]) begin
      j.beat.in_byte = stream_bytes[i];
      j.beat.is_last = (i == stream_bytes.size() - 1);
      j.hold = hold && (i == 0);
      text_jobs.push_back(j);
    end
    stream_bytes.delete();
  endtask

  task automatic put_body(input int n);
    repeat (n) begin
      case ($urandom_range(7))
        0: put_text("*");
        1: put_text("/");
        2: put_text("\\");
        3: stream_bytes.push_back($urandom_range(3) == 0 ? 8'h7F : 8'($urandom_range(31)));
        4: stream_bytes.push_back(8'($urandom_range(255, 128)));
        5: put_text(" ");
        6: put_text($urandom_range(1) ? "\"" : "'");
        default: stream_bytes.push_back(8'($urandom_range(8'h7A, 8'h61)));
      endcase
    end
  endtask

  task automatic add_token();
    string ident_chars;
    ident_chars = "abcdefghijklmnopqrstuvwxyz0123456789-#.%";
    case ($urandom_range(13))
      0, 1: begin
        repeat ($urandom_range(6, 1)) begin
          stream_bytes.push_back(ident_chars[$urandom_range(ident_chars.len() - 1)]);
        end
      end
      2, 3: begin
        repeat ($urandom_range(3, 1)) begin
          stream_bytes.push_back($urandom_range(2) == 0 ? 8'($urandom_range(8'h0D, 8'h09))
                                                        : CH_SPACE);
        end
      end
      4: put_text("{");
      5: put_text("}");
      6: put_text(";");
      7: put_text(":");
      8: put_text(",");
      9: begin
        put_text("/*");
        if ($urandom_range(2) == 0) begin
          put_text("-");
        end
        put_body($urandom_range(6));
        if ($urandom_range(4) != 0) begin
          put_text("*/");
        end
      end
      10: begin
        put_text("\"");
        put_body($urandom_range(6));
        if ($urandom_range(4) != 0) begin
          put_text("\"");
        end
      end
      11: begin
        put_text("'");
        put_body($urandom_range(6));
        if ($urandom_range(4) != 0) begin
          put_text("'");
        end
      end
      12: stream_bytes.push_back(8'($urandom_range(255)));
      default: put_text("  ");
    endcase
  endtask

  initial begin
    int streams;
    put_text("a  :\t{;}");
    close_stream(1'b0);
    put_text("/*-x*/");
    close_stream(1'b0);
    put_text("/*");
    stream_bytes.push_back(8'h00);
    put_text("*");
    close_stream(1'b0);
    put_text("\"\\\"");
    stream_bytes.push_back(8'hFF);
    close_stream(1'b0);
    put_text("'\\");
    close_stream(1'b0);
    put_text("/");
    close_stream(1'b0);
    put_text("x  ");
    close_stream(1'b0);
    streams = 0;
    while (text_jobs.size() < RANDOM_BEATS) begin
      repeat ($urandom_range(12, 2)) begin
        add_token();
      end
      close_stream(streams == 4 || streams == 15);
      streams++;
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (text_jobs.size() > 0 || text_valid || due_beats.size() > 0) begin
      @(posedge clk);
    end
    repeat (POST_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    while (idle_streak < WATCHDOG_LIMIT) begin
      @(posedge clk);
    end
    $display("== FAIL ==");
    $finish;
  end

  // A held beat is only released once every result of earlier beats has been seen.
  always @(negedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else if (!text_valid || text_took) begin
      if (text_jobs.size() > 0 && (!text_jobs[0].hold || due_beats.size() == 0) &&
          (quiet_phase || $urandom_range(99) >= 25)) begin
        next_job = text_jobs.pop_front();
        text_valid <= 1'b1;
        text_data <= next_job.beat;
      end else begin
        text_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      mini_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      mini_stall <= 1'b1;
    end else if (!held_once && text_count >= HOLD_START) begin
      held_once <= 1'b1;
      hold_left <= HOLD_CYCLES;
      mini_stall <= 1'b1;
    end else begin
      mini_stall <= !quiet_phase && ($urandom_range(99) < 25);
    end
  end

  always @(posedge clk) begin
    text_took <= !rst && text_valid && !text_stall;
    if (!rst) begin
      if (text_valid && !text_stall) begin
        minify_byte(text_data);
        text_count++;
      end
      if (mini_valid && !mini_stall) begin
        if (due_beats.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected beat: byte %h valid %b end %b done %b",
                     mini_data.out_byte, mini_data.byte_valid, mini_data.run_end,
                     mini_data.stream_done);
          end
          fail_count++;
        end else begin
          want = due_beats.pop_front();
          if (want.out_byte !== mini_data.out_byte || want.byte_valid !== mini_data.byte_valid ||
              want.run_end !== mini_data.run_end ||
              want.stream_done !== mini_data.stream_done) begin
            if (fail_count < 10) begin
              $display("mismatch: expected byte %h valid %b end %b done %b, got %h %b %b %b",
                       want.out_byte, want.byte_valid, want.run_end, want.stream_done,
                       mini_data.out_byte, mini_data.byte_valid, mini_data.run_end,
                       mini_data.stream_done);
            end
            fail_count++;
          end
        end
      end
      if ((text_valid && !text_stall) || (mini_valid && !mini_stall)) begin
        idle_streak = 0;
      end else begin
        idle_streak++;
      end
    end
  end

endmodule
